// ----- src/pgbq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the gray Bayer quantiser.
// No dependencies; every other file of the block imports this package.
package pgbq_pkg;

   // Source pixel formats
   localparam logic [2:0] FMT_INDEXED_1 = 3'd0;
   localparam logic [2:0] FMT_INDEXED_2 = 3'd1;
   localparam logic [2:0] FMT_INDEXED_4 = 3'd2;
   localparam logic [2:0] FMT_INDEXED_8 = 3'd3;
   localparam logic [2:0] FMT_RGB16     = 3'd4;
   localparam logic [2:0] FMT_BGR24     = 3'd5;

   // Item actions
   localparam logic ACT_PALETTE_WRITE = 1'b0;
   localparam logic ACT_PIXEL         = 1'b1;

   // Register indexes (byte address bits 3:2)
   localparam logic [1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_IS_565        = 2'd1;
   localparam logic [1:0] CSR_PLANE_MODE    = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Dither offset and luma weights
   localparam logic [9:0]  DITHER_BIAS = 10'd30;
   localparam logic [15:0] LUMA_R      = 16'd77;
   localparam logic [15:0] LUMA_G      = 16'd150;
   localparam logic [15:0] LUMA_B      = 16'd29;

   typedef logic [3:0] bayer_table_type [16];
   typedef logic [7:0] exp5_table_type [32];
   typedef logic [7:0] exp6_table_type [64];

   // 4x4 Bayer matrix, indexed by {row[1:0], column[1:0]}
   localparam bayer_table_type BAYER_TABLE = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   // Build the 5-bit to 8-bit expansion table, floor(x*255/31)
   function automatic exp5_table_type build_exp5();
      exp5_table_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255) / 31);
      end
      return t;
   endfunction

   // Build the 6-bit to 8-bit expansion table, floor(x*255/63)
   function automatic exp6_table_type build_exp6();
      exp6_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam exp5_table_type EXP5_TABLE = build_exp5();
   localparam exp6_table_type EXP6_TABLE = build_exp6();

   // One queued pixel: luma plus what the back end needs for dither and packing
   typedef struct packed {
      logic [7:0] gray;
      logic [2:0] col_lo;
      logic [1:0] row_lo;
      logic       last;
   } queue_entry_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] gray_value;
      logic [1:0] dither_level;
      logic       bw_bit;
      logic       red_bit;
      logic       byte_ready;
      logic [7:0] packed_byte;
      logic [7:0] red_plane_byte;
   } rsp_type;

endpackage

// ----- src/pgbq_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, owns the palette memory, decodes pixels to luma.
// Depends on pgbq_pkg; feeds pgbq_queue.
module pgbq_front import pgbq_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            action,
   input  logic [7:0]      table_index,
   input  logic [7:0]      table_blue,
   input  logic [7:0]      table_green,
   input  logic [7:0]      table_red,
   input  logic [23:0]     raw_pixel,
   input  logic [11:0]     pixel_column,
   input  logic [11:0]     pixel_row,
   input  logic            row_end,
   input  logic [2:0]      source_format,
   input  logic            is_565,
   input  logic            queue_full,
   output logic            push_valid,
   output queue_entry_type push_entry
);

   localparam int         IDX_W       = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

   logic [23:0] palette_mem [PALETTE_ENTRIES];
   logic [23:0] pal_rd_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [23:0] s1_raw_ff;
   logic [2:0]  s1_col_ff;
   logic [1:0]  s1_row_ff;
   logic        s1_last_ff;
   logic        s1_hit_ff;

   logic        accept, pix_accept, wr_accept;
   logic [7:0]  rd_index;
   logic        rd_hit;
   logic [15:0] word16;
   logic [7:0]  red, green, blue;
   logic [15:0] luma_sum;

   // Handshake: the stage register frees when its pixel moves into the queue
   assign push_valid = s1_valid_ff && !queue_full;
   assign req_ready  = !s1_valid_ff || push_valid;
   assign accept     = req_valid && req_ready;
   assign pix_accept = accept && (action == ACT_PIXEL);
   assign wr_accept  = accept && (action == ACT_PALETTE_WRITE)
                       && ({1'b0, table_index} < ENTRY_LIMIT);

   // Pick the palette index out of the raw word
   always_comb begin
      unique case (source_format)
         FMT_INDEXED_1: rd_index = {7'b0, raw_pixel[0]};
         FMT_INDEXED_2: rd_index = {6'b0, raw_pixel[1:0]};
         FMT_INDEXED_4: rd_index = {4'b0, raw_pixel[3:0]};
         default:       rd_index = raw_pixel[7:0];
      endcase
   end
   assign rd_hit = ({1'b0, rd_index} < ENTRY_LIMIT);

   // Palette memory: write on a palette transaction, registered read on a pixel
   always_ff @(posedge clock) begin
      if (wr_accept) begin
         palette_mem[table_index[IDX_W-1:0]] <= {table_red, table_green, table_blue};
      end
      if (pix_accept) begin
         pal_rd_ff <= palette_mem[rd_index[IDX_W-1:0]];
      end
   end

   // Stage register control
   always_comb begin
      if (pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (push_valid) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage register payload
   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_raw_ff  <= raw_pixel;
         s1_col_ff  <= pixel_column[2:0];
         s1_row_ff  <= pixel_row[1:0];
         s1_last_ff <= row_end;
         s1_hit_ff  <= rd_hit;
      end
   end

   // Decode the held pixel to R, G, B
   assign word16 = s1_raw_ff[15:0];
   always_comb begin
      unique case (source_format) inside
         FMT_INDEXED_1, FMT_INDEXED_2, FMT_INDEXED_4, FMT_INDEXED_8: begin
            if (s1_hit_ff) begin
               red   = pal_rd_ff[23:16];
               green = pal_rd_ff[15:8];
               blue  = pal_rd_ff[7:0];
            end else begin
               red   = 8'd0;
               green = 8'd0;
               blue  = 8'd0;
            end
         end
         FMT_RGB16: begin
            if (is_565) begin
               red   = EXP5_TABLE[word16[15:11]];
               green = EXP6_TABLE[word16[10:5]];
               blue  = EXP5_TABLE[word16[4:0]];
            end else begin
               blue  = EXP5_TABLE[word16[14:10]];
               green = EXP5_TABLE[word16[9:5]];
               red   = EXP5_TABLE[word16[4:0]];
            end
         end
         default: begin
            blue  = s1_raw_ff[7:0];
            green = s1_raw_ff[15:8];
            red   = s1_raw_ff[23:16];
         end
      endcase
   end

   // Weighted luma sum; the top byte is the gray value
   assign luma_sum = ({8'b0, red} * LUMA_R) + ({8'b0, green} * LUMA_G)
                     + ({8'b0, blue} * LUMA_B);

   assign push_entry.gray   = luma_sum[15:8];
   assign push_entry.col_lo = s1_col_ff;
   assign push_entry.row_lo = s1_row_ff;
   assign push_entry.last   = s1_last_ff;

endmodule

// ----- src/pgbq_queue.sv -----
`timescale 1ns / 1ps
// Short queue of decoded pixels between the front and back ends.
// Depends on pgbq_pkg for the entry type and depth.
module pgbq_queue import pgbq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output queue_entry_type pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/pgbq_back.sv -----
`timescale 1ns / 1ps
// Back end: Bayer dither, level packing and the result output register.
// Depends on pgbq_pkg; drains pgbq_queue.
module pgbq_back import pgbq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            plane_mode,
   input  logic            entry_valid,
   input  queue_entry_type entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic [7:0] pack_acc_ff, pack_acc_in;
   logic [7:0] red_acc_ff, red_acc_in;

   logic [3:0] bayer;
   logic [9:0] biased;
   logic [9:0] shifted;
   logic [7:0] clamped;
   logic [1:0] level;
   logic [7:0] mask;
   logic [7:0] pack_next, red_next;
   logic       emit;
   rsp_type    result;

   assign pop = entry_valid && (!rsp_valid_ff || rsp_ready);

   // Dither: gray + 4*bayer - 30, clamp to a byte, invert the top two bits
   assign bayer   = BAYER_TABLE[{entry.row_lo, entry.col_lo[1:0]}];
   assign biased  = {2'b0, entry.gray} + {4'b0, bayer, 2'b00};
   assign shifted = biased - DITHER_BIAS;
   always_comb begin
      if (biased < DITHER_BIAS) begin
         clamped = 8'd0;
      end else if (shifted[9:8] != 2'b00) begin
         clamped = 8'hFF;
      end else begin
         clamped = shifted[7:0];
      end
   end
   assign level = ~clamped[7:6];

   // Pack the level into the accumulators
   assign mask = 8'h80 >> entry.col_lo;
   always_comb begin
      if (plane_mode) begin
         pack_next = pack_acc_ff | (level[0] ? mask : 8'h00);
         red_next  = red_acc_ff  | (level[1] ? mask : 8'h00);
         emit      = (entry.col_lo == 3'd7) || entry.last;
      end else begin
         pack_next = pack_acc_ff | ({6'b0, level} << {~entry.col_lo[1:0], 1'b0});
         red_next  = red_acc_ff;
         emit      = (entry.col_lo[1:0] == 2'd3) || entry.last;
      end
   end

   // Assemble the result transaction
   always_comb begin
      result.gray_value     = entry.gray;
      result.dither_level   = level;
      result.bw_bit         = level[0];
      result.red_bit        = level[1];
      result.byte_ready     = emit;
      result.packed_byte    = emit ? pack_next : 8'h00;
      result.red_plane_byte = (emit && plane_mode) ? red_next : 8'h00;
   end

   // Accumulators clear after an emit; the red one only in plane mode
   always_comb begin
      pack_acc_in = pack_acc_ff;
      red_acc_in  = red_acc_ff;
      if (pop) begin
         pack_acc_in = emit ? 8'h00 : pack_next;
         red_acc_in  = (emit && plane_mode) ? 8'h00 : red_next;
      end
   end

   // Output register control
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pack_acc_ff  <= 8'h00;
         red_acc_ff   <= 8'h00;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pack_acc_ff  <= pack_acc_in;
         red_acc_ff   <= red_acc_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/pixel_gray_bayer_quantizer_core.sv -----
`timescale 1ns / 1ps
// Top level of the gray Bayer quantiser: register port, front end, queue, back end.
// Depends on pgbq_pkg, pgbq_front, pgbq_queue and pgbq_back.
//
// Turns one source pixel per transaction into a 2-bit e-paper level (0 white .. 3 black)
// by palette lookup or colour expansion, luma, and 4x4 Bayer dither, then packs levels
// MSB-first into 2bpp bytes or two 1bpp plane bytes. One transaction is accepted every
// clock unless a full queue or a held result stalls the front; a palette write gives no
// result. The accepting edge loads a pixel into the palette read register and the stage
// register; from there the decoded pixel moves into the two-entry queue and then into the
// output register. The single palette memory port serves one transaction per cycle.
// The user must write configuration through the register port only while no transaction
// is in flight; the block itself does not enforce it.
module pixel_gray_bayer_quantizer_core import pgbq_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_blue,
   input  logic [7:0]  req_table_green,
   input  logic [7:0]  req_table_red,
   input  logic [23:0] req_raw_pixel,
   input  logic [11:0] req_pixel_column,
   input  logic [11:0] req_pixel_row,
   input  logic        req_row_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_gray_value,
   output logic [1:0]  rsp_dither_level,
   output logic        rsp_bw_bit,
   output logic        rsp_red_bit,
   output logic        rsp_byte_ready,
   output logic [7:0]  rsp_packed_byte,
   output logic [7:0]  rsp_red_plane_byte,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0] source_format_ff;
   logic       is_565_ff;
   logic       plane_mode_ff;
   logic       csr_write;

   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            queue_not_empty;
   queue_entry_type pop_entry;
   logic            pop;
   rsp_type         rsp;

   // Register port: always ready, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= FMT_BGR24;
         is_565_ff        <= 1'b0;
         plane_mode_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            CSR_SOURCE_FORMAT: source_format_ff <= pwdata[2:0];
            CSR_IS_565:        is_565_ff        <= pwdata[0];
            CSR_PLANE_MODE:    plane_mode_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (paddr[3:2])
         CSR_SOURCE_FORMAT: prdata = {29'b0, source_format_ff};
         CSR_IS_565:        prdata = {31'b0, is_565_ff};
         CSR_PLANE_MODE:    prdata = {31'b0, plane_mode_ff};
         default:           prdata = 32'b0;
      endcase
   end

   pgbq_front #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .action       (req_action),
      .table_index  (req_table_index),
      .table_blue   (req_table_blue),
      .table_green  (req_table_green),
      .table_red    (req_table_red),
      .raw_pixel    (req_raw_pixel),
      .pixel_column (req_pixel_column),
      .pixel_row    (req_pixel_row),
      .row_end      (req_row_end),
      .source_format(source_format_ff),
      .is_565       (is_565_ff),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   pgbq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_entry (pop_entry)
   );

   pgbq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .plane_mode (plane_mode_ff),
      .entry_valid(queue_not_empty),
      .entry      (pop_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_gray_value     = rsp.gray_value;
   assign rsp_dither_level   = rsp.dither_level;
   assign rsp_bw_bit         = rsp.bw_bit;
   assign rsp_red_bit        = rsp.red_bit;
   assign rsp_byte_ready     = rsp.byte_ready;
   assign rsp_packed_byte    = rsp.packed_byte;
   assign rsp_red_plane_byte = rsp.red_plane_byte;

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("pixel pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty)
      else $error("pop from empty queue");

   // A result without a finished byte carries zero bytes
   a_idle_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_ready) |-> (rsp_packed_byte == 8'h00
                                          && rsp_red_plane_byte == 8'h00))
      else $error("packed bytes non-zero without byte_ready");

   // A popped pixel shows up as a valid result at the next edge
   a_pop_to_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped pixel did not reach the output register");

endmodule

// ----- sim/tb_pixel_gray_bayer_quantizer_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pixel_gray_bayer_quantizer_core: luma, Bayer dither and packing.
// Depends on pgbq_pkg and the core; a scoreboard class predicts every pixel result.
module tb_pixel_gray_bayer_quantizer_core import pgbq_pkg::*;;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int REPORT_LINES    = 60;
   localparam int PHASES          = 12;
   localparam int RANDOM_PIXELS   = 60;

   // Per-phase register settings, extremes and the unused format codes included
   localparam int PHASE_FMT   [PHASES] = '{0, 1, 2, 3, 4, 4, 5, 6, 7, 3, 4, 0};
   localparam int PHASE_565   [PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 1, 0, 1};
   localparam int PHASE_PLANE [PHASES] = '{1, 0, 1, 0, 0, 1, 1, 0, 1, 1, 0, 0};

   // Ordered dither thresholds, [row][column]
   localparam int DITHER_MAP [4][4] = '{
      '{0, 8, 2, 10}, '{12, 4, 14, 6}, '{3, 11, 1, 9}, '{15, 7, 13, 5}
   };

   // One input transaction
   typedef struct {
      logic        action;
      logic [7:0]  index;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [23:0] raw;
      logic [11:0] column;
      logic [11:0] row;
      logic        row_end;
   } quant_item_type;

   // Predicts levels and packed bytes, and holds the results still owed by the block
   class quant_scoreboard;
      logic [23:0] palette [256];
      logic [7:0]  pack_acc;
      logic [7:0]  red_acc;
      logic [2:0]  fmt;
      logic        rgb565;
      logic        planes;
      rsp_type     expected_levels [$];
      int          result_count;
      int          fail_count;

      function new();
         pack_acc = '0;
         red_acc = '0;
         fmt = FMT_BGR24;
         rgb565 = 1'b0;
         planes = 1'b0;
         result_count = 0;
         fail_count = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_SOURCE_FORMAT: fmt = value[2:0];
            CSR_IS_565:        rgb565 = value[0];
            CSR_PLANE_MODE:    planes = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function int stretch(int v, int top);
         return (v * 255) / top;
      endfunction

      // Decode, dither and pack one pixel, advancing the accumulators
      function rsp_type predict_levels(quant_item_type it);
         int r, g, b, gray, adj;
         logic [7:0]  idx;
         logic [15:0] w;
         logic [23:0] e;
         logic [1:0]  lvl;
         rsp_type     res;
         r = 0;
         g = 0;
         b = 0;
         w = it.raw[15:0];
         case (fmt)
            FMT_INDEXED_1, FMT_INDEXED_2, FMT_INDEXED_4, FMT_INDEXED_8: begin
               idx = it.raw[7:0] & 8'((1 << (1 << fmt)) - 1);
               e = palette[idx];
               b = int'(e[7:0]);
               g = int'(e[15:8]);
               r = int'(e[23:16]);
            end
            FMT_RGB16: begin
               if (rgb565) begin
                  r = stretch(int'(w[15:11]), 31);
                  g = stretch(int'(w[10:5]), 63);
                  b = stretch(int'(w[4:0]), 31);
               end else begin
                  b = stretch(int'(w[14:10]), 31);
                  g = stretch(int'(w[9:5]), 31);
                  r = stretch(int'(w[4:0]), 31);
               end
            end
            default: begin
               b = int'(it.raw[7:0]);
               g = int'(it.raw[15:8]);
               r = int'(it.raw[23:16]);
            end
         endcase
         gray = ((r * 77 + g * 150 + b * 29) >> 8) & 255;
         adj = gray + 4 * DITHER_MAP[it.row[1:0]][it.column[1:0]] - 30;
         if (adj < 0) adj = 0;
         if (adj > 255) adj = 255;
         lvl = 2'(3 - (adj >> 6));
         res = '0;
         res.gray_value = 8'(gray);
         res.dither_level = lvl;
         res.bw_bit = lvl[0];
         res.red_bit = lvl[1];
         if (planes) begin
            if (lvl[0]) pack_acc = pack_acc | (8'h80 >> it.column[2:0]);
            if (lvl[1]) red_acc = red_acc | (8'h80 >> it.column[2:0]);
            if (it.column[2:0] == 3'd7 || it.row_end) begin
               res.byte_ready = 1'b1;
               res.packed_byte = pack_acc;
               res.red_plane_byte = red_acc;
               pack_acc = '0;
               red_acc = '0;
            end
         end else begin
            pack_acc = pack_acc | (8'(lvl) << (6 - 2 * int'(it.column[1:0])));
            if (it.column[1:0] == 2'd3 || it.row_end) begin
               res.byte_ready = 1'b1;
               res.packed_byte = pack_acc;
               pack_acc = '0;
            end
         end
         return res;
      endfunction

      // Store a palette write, or queue the prediction for a pixel
      function void note_item(quant_item_type it);
         if (it.action == ACT_PALETTE_WRITE) begin
            palette[it.index] = {it.red, it.green, it.blue};
         end else begin
            expected_levels.push_back(predict_levels(it));
         end
      endfunction

      task report(string msg);
         if (fail_count < REPORT_LINES) $display("mismatch: %s", msg);
         fail_count++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("result %0d %s got 0x%0h, want 0x%0h",
                             result_count, name, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         result_count++;
         if (expected_levels.size() == 0) begin
            report($sformatf("result %0d arrived with nothing outstanding", result_count));
         end else begin
            want = expected_levels.pop_front();
            check_field("gray_value", 32'(got.gray_value), 32'(want.gray_value));
            check_field("dither_level", 32'(got.dither_level), 32'(want.dither_level));
            check_field("bw_bit", 32'(got.bw_bit), 32'(want.bw_bit));
            check_field("red_bit", 32'(got.red_bit), 32'(want.red_bit));
            check_field("byte_ready", 32'(got.byte_ready), 32'(want.byte_ready));
            check_field("packed_byte", 32'(got.packed_byte), 32'(want.packed_byte));
            check_field("red_plane_byte", 32'(got.red_plane_byte),
                        32'(want.red_plane_byte));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_table_index;
   logic [7:0]  req_table_blue;
   logic [7:0]  req_table_green;
   logic [7:0]  req_table_red;
   logic [23:0] req_raw_pixel;
   logic [11:0] req_pixel_column;
   logic [11:0] req_pixel_row;
   logic        req_row_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_gray_value;
   logic [1:0]  rsp_dither_level;
   logic        rsp_bw_bit;
   logic        rsp_red_bit;
   logic        rsp_byte_ready;
   logic [7:0]  rsp_packed_byte;
   logic [7:0]  rsp_red_plane_byte;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   quant_scoreboard quant;
   bit              hold_off_req;
   bit              no_idle;

   pixel_gray_bayer_quantizer_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_table_index   (req_table_index),
      .req_table_blue    (req_table_blue),
      .req_table_green   (req_table_green),
      .req_table_red     (req_table_red),
      .req_raw_pixel     (req_raw_pixel),
      .req_pixel_column  (req_pixel_column),
      .req_pixel_row     (req_pixel_row),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gray_value    (rsp_gray_value),
      .rsp_dither_level  (rsp_dither_level),
      .rsp_bw_bit        (rsp_bw_bit),
      .rsp_red_bit       (rsp_red_bit),
      .rsp_byte_ready    (rsp_byte_ready),
      .rsp_packed_byte   (rsp_packed_byte),
      .rsp_red_plane_byte(rsp_red_plane_byte),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Free-running clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Note accepted inputs and check accepted results on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            quant.note_item('{req_action, req_table_index, req_table_blue, req_table_green,
                              req_table_red, req_raw_pixel, req_pixel_column, req_pixel_row,
                              req_row_end});
         end
         if (rsp_valid && rsp_ready) begin
            quant.check_result('{gray_value: rsp_gray_value, dither_level: rsp_dither_level,
                                 bw_bit: rsp_bw_bit, red_bit: rsp_red_bit,
                                 byte_ready: rsp_byte_ready, packed_byte: rsp_packed_byte,
                                 red_plane_byte: rsp_red_plane_byte});
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request
   initial begin : result_sink
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (no_idle || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic drive_item(input quant_item_type it);
      req_valid        <= 1'b1;
      req_action       <= it.action;
      req_table_index  <= it.index;
      req_table_blue   <= it.blue;
      req_table_green  <= it.green;
      req_table_red    <= it.red;
      req_raw_pixel    <= it.raw;
      req_pixel_column <= it.column;
      req_pixel_row    <= it.row;
      req_row_end      <= it.row_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Send, then maybe drop valid for a while
   task automatic offer(input quant_item_type it);
      drive_item(it);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   function automatic quant_item_type random_item();
      quant_item_type it;
      it.action  = 1'($urandom);
      it.index   = 8'($urandom);
      it.blue    = 8'($urandom);
      it.green   = 8'($urandom);
      it.red     = 8'($urandom);
      it.raw     = 24'($urandom);
      it.column  = 12'($urandom);
      it.row     = 12'($urandom);
      it.row_end = 1'($urandom);
      return it;
   endfunction

   task automatic write_palette(input logic [7:0] idx, input logic [23:0] rgb);
      quant_item_type it;
      it = random_item();
      it.action = ACT_PALETTE_WRITE;
      it.index = idx;
      {it.red, it.green, it.blue} = rgb;
      offer(it);
   endtask

   task automatic pixel(input logic [23:0] raw, input int col, input int row, input bit last);
      quant_item_type it;
      it = random_item();
      it.action = ACT_PIXEL;
      it.raw = raw;
      it.column = 12'(col);
      it.row = 12'(row);
      it.row_end = last;
      offer(it);
   endtask

   // Drop valid, let the last acceptance be noted, wait for every owed result,
   // then let the pipeline settle
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quant.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      quant.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic reconfigure(input int fmt, input int rgb565, input int planes);
      drain_block();
      write_csr(CSR_SOURCE_FORMAT, 32'(fmt));
      write_csr(CSR_IS_565, 32'(rgb565));
      write_csr(CSR_PLANE_MODE, 32'(planes));
   endtask

   // Rows of consecutive columns with random content, laced with palette writes,
   // stray pixels and rows whose end mark is missing or early
   task automatic stream_pixels(input int count, input bit pause_midway);
      quant_item_type it;
      int             done, width, x;
      logic [11:0]    first, y;
      bit             paused;
      done = 0;
      paused = 1'b0;
      while (done < count) begin
         width = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
         first = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0;
         y = 12'($urandom);
         for (x = 0; x < width && done < count; x++) begin
            if ($urandom_range(0, 99) < 8) begin
               it = random_item();
               it.action = ACT_PALETTE_WRITE;
               offer(it);
            end
            if ($urandom_range(0, 99) < 5) begin
               it = random_item();
               it.action = ACT_PIXEL;
               offer(it);
               done++;
            end
            it = random_item();
            it.action = ACT_PIXEL;
            case ($urandom_range(0, 9))
               0: it.raw = 24'h000000;
               1: it.raw = 24'hffffff;
               default: it.raw = 24'($urandom);
            endcase
            it.column = first + 12'(x);
            it.row = y;
            it.row_end = (x == width - 1) ^ ($urandom_range(0, 19) == 0);
            offer(it);
            done++;
            // Hold the sender until the block has handed back everything
            if (pause_midway && !paused && done >= count / 2) begin
               drain_block();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin : stimulus
      int p;
      quant = new();
      hold_off_req = 1'b0;
      no_idle = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_PALETTE_WRITE;
      req_table_index  <= '0;
      req_table_blue   <= '0;
      req_table_green  <= '0;
      req_table_red    <= '0;
      req_raw_pixel    <= '0;
      req_pixel_column <= '0;
      req_pixel_row    <= '0;
      req_row_end      <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole palette so no pixel ever reads an unwritten entry
      for (p = 0; p < 256; p++) begin
         if (p == 0) write_palette(8'(p), 24'h000000);
         else if (p == 1 || p == 255) write_palette(8'(p), 24'hffffff);
         else write_palette(8'(p), 24'($urandom));
      end

      // Directed: black, white and grey across a group, a partial flush, a repeated
      // slot, the top column and row, then 1bpp planes and RGB565 extremes
      pixel(24'h000000, 0, 0, 1'b0);
      pixel(24'hffffff, 1, 0, 1'b0);
      pixel(24'h808080, 2, 0, 1'b0);
      pixel(24'hffffff, 3, 0, 1'b0);
      pixel(24'hff0000, 0, 1, 1'b1);
      pixel(24'h00ff00, 5, 2, 1'b0);
      pixel(24'h0000ff, 6, 3, 1'b0);
      pixel(24'h404040, 6, 3, 1'b1);
      pixel(24'hffffff, 4095, 4095, 1'b1);
      write_palette(8'd0, 24'h000000);
      reconfigure(FMT_INDEXED_1, 0, 1);
      for (p = 0; p < 8; p++) pixel({23'h7fffff, 1'(p)}, p, 3, 1'b0);
      reconfigure(FMT_RGB16, 1, 1);
      pixel(24'hffffff, 0, 0, 1'b0);
      pixel(24'h00f800, 1, 0, 1'b1);

      // Random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         reconfigure(PHASE_FMT[p], PHASE_565[p], PHASE_PLANE[p]);
         no_idle = (p % 4 == 1);
         if (p == 2) begin
            no_idle = 1'b1;
            hold_off_req = 1'b1;
         end
         stream_pixels(RANDOM_PIXELS, p == 7);
      end
      no_idle = 1'b0;
      drain_block();

      if (quant.fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
